// ===== rtl/hhw_pkg.sv =====
// Shared types and constants for the Hann/Hamming window block.
`default_nettype none
package hhw_pkg;

   localparam int unsigned CSR_INDEX_W  = 2;
   localparam int unsigned CSR_DATA_W   = 17;
   localparam int unsigned MODE_W       = 2;
   localparam int unsigned FRAME_LEN_W  = 13;
   localparam int unsigned PHASE_STEP_W = 17;
   localparam int unsigned PHASE_W      = 16;
   localparam int unsigned COS_W        = 16;
   localparam int unsigned COEF_W       = 17;

   localparam logic [FRAME_LEN_W-1:0]  FRAME_LEN_RESET  = 13'd1024;
   localparam logic [PHASE_STEP_W-1:0] PHASE_STEP_RESET = 17'd64;

   // Hamming: w = (35389*32768 - 30147*c + 16384) >> 15
   localparam logic [14:0]        HAMMING_B    = 15'd30147;
   localparam logic signed [33:0] HAMMING_BIAS = 34'sd1159643136;
   localparam logic signed [17:0] HANN_ONE     = 18'sd32768;

   typedef enum logic [MODE_W-1:0] {
      MODE_PASS    = 2'd0,
      MODE_HANN    = 2'd1,
      MODE_HAMMING = 2'd2
   } window_mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_MODE  = 2'd0,
      CSR_FRAME_LENGTH = 2'd1,
      CSR_PHASE_STEP   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COEF,
      ST_MUL,
      ST_SEND
   } seq_state_type;

   typedef struct packed {
      logic accept;
      logic coef_en;
      logic mul_en;
      logic out_load;
   } dp_ctrl_type;

endpackage
`default_nettype wire

// ===== rtl/hhw_if.sv =====
// Channel interfaces: sample input, windowed result and register write.
`default_nettype none
interface hhw_req_if #(parameter int unsigned SAMPLE_WIDTH = 24) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface hhw_rsp_if #(parameter int unsigned SAMPLE_WIDTH = 24) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] windowed_sample;
   logic                           last_of_frame;
   modport source (output valid, output windowed_sample, output last_of_frame, input ready);
   modport sink   (input valid, input windowed_sample, input last_of_frame, output ready);
endinterface

interface hhw_csr_if import hhw_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/hhw_cos_rom.sv =====
// Quarter-wave cosine ROM in Q1.15 with a registered read port.
`default_nettype none
module hhw_cos_rom
   import hhw_pkg::*;
#(
   parameter int unsigned COS_TABLE_DEPTH = 1024
) (
   input  wire logic                               clock,
   input  wire logic [$clog2(COS_TABLE_DEPTH)-1:0] rd_addr,
   output logic      [COS_W-1:0]                   rd_data
);

   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef logic [COS_W-1:0] rom_type [COS_TABLE_DEPTH];

   // Taylor series of cos in Q2.30, Horner form, each stage truncated
   function automatic logic [COS_W-1:0] cos_entry(input logic [63:0] k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] q;
      logic [63:0] v;
      x  = (k * HALF_PI_Q30) / 64'(COS_TABLE_DEPTH);
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      q  = ((x2 * t) >> 30) / 64'd132;
      t  = (q >= Q30_ONE) ? 64'd0 : Q30_ONE - q;
      q  = ((x2 * t) >> 30) / 64'd90;
      t  = (q >= Q30_ONE) ? 64'd0 : Q30_ONE - q;
      q  = ((x2 * t) >> 30) / 64'd56;
      t  = (q >= Q30_ONE) ? 64'd0 : Q30_ONE - q;
      q  = ((x2 * t) >> 30) / 64'd30;
      t  = (q >= Q30_ONE) ? 64'd0 : Q30_ONE - q;
      q  = ((x2 * t) >> 30) / 64'd12;
      t  = (q >= Q30_ONE) ? 64'd0 : Q30_ONE - q;
      q  = ((x2 * t) >> 30) / 64'd2;
      t  = (q >= Q30_ONE) ? 64'd0 : Q30_ONE - q;
      v  = (t + 64'd16384) >> 15;
      if (v > 64'd32768) begin
         v = 64'd32768;
      end
      return v[COS_W-1:0];
   endfunction

   function automatic rom_type build_rom();
      rom_type r;
      for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
         r[k] = cos_entry(64'(k));
      end
      return r;
   endfunction

   localparam rom_type COS_ROM = build_rom();

   logic [COS_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= COS_ROM[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/hhw_wdp.sv =====
// Window datapath: cosine lookup, coefficient, product and result register.
`default_nettype none
module hhw_wdp
   import hhw_pkg::*;
#(
   parameter int unsigned SAMPLE_WIDTH    = 24,
   parameter int unsigned COS_TABLE_DEPTH = 1024
) (
   input  wire logic                           clock,
   input  wire dp_ctrl_type                    ctrl,
   input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
   input  wire logic        [PHASE_W-1:0]      phase,
   input  wire logic        [MODE_W-1:0]       mode,
   input  wire logic                           last_in,
   output logic signed      [SAMPLE_WIDTH-1:0] windowed_sample,
   output logic                                last_of_frame
);

   localparam int unsigned A_W   = $clog2(COS_TABLE_DEPTH);
   localparam int unsigned SCL_W = 14 + A_W + 1;
   localparam int unsigned PRD_W = SAMPLE_WIDTH + 18;

   // lookup address from the phase
   logic [SCL_W-1:0] scaled;
   logic [A_W-1:0]   tbl_idx;
   logic [A_W:0]     tbl_mir;
   logic [1:0]       quad;
   logic             mirror;
   logic             mir_zero;
   logic [A_W-1:0]   rom_addr;
   logic [COS_W-1:0] rom_data;

   assign quad     = phase[PHASE_W-1 -: 2];
   assign scaled   = SCL_W'(phase[13:0]) * SCL_W'(COS_TABLE_DEPTH);
   assign tbl_idx  = scaled[14 +: A_W];
   assign tbl_mir  = (A_W+1)'(COS_TABLE_DEPTH) - {1'b0, tbl_idx};
   assign mirror   = quad[0];
   assign mir_zero = mirror && (tbl_idx == '0);
   assign rom_addr = mirror ? (mir_zero ? '0 : tbl_mir[A_W-1:0]) : tbl_idx;

   hhw_cos_rom #(
      .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
   ) u_cos_rom (
      .clock   (clock),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   // beat capture
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic                           active_ff;
   logic                           hamm_ff;
   logic                           neg_ff;
   logic                           zero_ff;
   logic                           last_ff;

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         sample_ff <= sample_in;
         active_ff <= (mode == MODE_HANN) || (mode == MODE_HAMMING);
         hamm_ff   <= (mode == MODE_HAMMING);
         neg_ff    <= quad[0] ^ quad[1];
         zero_ff   <= mir_zero;
         last_ff   <= last_in;
      end
   end

   // coefficient
   logic        [COS_W-1:0]  cos_mag;
   logic signed [COS_W:0]    cos_val;
   logic signed [17:0]       hann_full;
   logic signed [32:0]       ham_prod;
   logic signed [33:0]       ham_num;
   logic        [COEF_W-1:0] coef_in;
   logic        [COEF_W-1:0] coef_ff;

   assign cos_mag   = zero_ff ? '0 : rom_data;
   assign cos_val   = neg_ff ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
   assign hann_full = HANN_ONE - 18'(cos_val);
   assign ham_prod  = 33'(signed'({1'b0, HAMMING_B})) * 33'(cos_val);
   assign ham_num   = HAMMING_BIAS - 34'(ham_prod);
   assign coef_in   = hamm_ff ? ham_num[15 +: COEF_W] : hann_full[COEF_W-1:0];

   always_ff @(posedge clock) begin
      if (ctrl.coef_en) begin
         coef_ff <= coef_in;
      end
   end

   // product, rounded half up
   logic signed [PRD_W-1:0]        prod;
   logic signed [PRD_W-1:0]        prod_rnd;
   logic signed [SAMPLE_WIDTH-1:0] result_in;
   logic signed [SAMPLE_WIDTH-1:0] result_ff;

   assign prod      = PRD_W'(sample_ff) * PRD_W'(signed'({1'b0, coef_ff}));
   assign prod_rnd  = prod + PRD_W'(32768);
   assign result_in = active_ff ? prod_rnd[16 +: SAMPLE_WIDTH] : sample_ff;

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         result_ff <= result_in;
      end
   end

   // output register
   logic signed [SAMPLE_WIDTH-1:0] windowed_sample_ff;
   logic                           last_of_frame_ff;

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         windowed_sample_ff <= result_ff;
         last_of_frame_ff   <= last_ff;
      end
   end

   assign windowed_sample = windowed_sample_ff;
   assign last_of_frame   = last_of_frame_ff;

endmodule
`default_nettype wire

// ===== rtl/hhw_seq.sv =====
// Sequencer: registers, frame index, phase accumulator and handshakes.
`default_nettype none
module hhw_seq
   import hhw_pkg::*;
#(
   parameter int unsigned MAX_FRAME = 4096
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output dp_ctrl_type                 ctrl,
   output logic      [PHASE_W-1:0]     phase,
   output logic      [MODE_W-1:0]      mode,
   output logic                        last_out
);

   localparam int unsigned IDX_W = $clog2(MAX_FRAME);
   localparam int unsigned N_W   = (IDX_W + 1 > FRAME_LEN_W) ? IDX_W + 1 : FRAME_LEN_W;
   localparam logic [N_W-1:0] MAX_N = N_W'(MAX_FRAME);

   seq_state_type             state_ff;
   seq_state_type             state_in;
   logic [MODE_W-1:0]         mode_ff;
   logic [MODE_W-1:0]         mode_in;
   logic [FRAME_LEN_W-1:0]    frame_length_ff;
   logic [FRAME_LEN_W-1:0]    frame_length_in;
   logic [PHASE_STEP_W-1:0]   phase_step_ff;
   logic [PHASE_STEP_W-1:0]   phase_step_in;
   logic [IDX_W-1:0]          idx_ff;
   logic [IDX_W-1:0]          idx_in;
   logic [PHASE_W-1:0]        phase_ff;
   logic [PHASE_W-1:0]        phase_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;

   logic [N_W-1:0] fl_ext;
   logic [N_W-1:0] n_eff;
   logic           last_item;

   assign fl_ext    = N_W'(frame_length_ff);
   assign n_eff     = (fl_ext == '0) ? N_W'(1) : ((fl_ext > MAX_N) ? MAX_N : fl_ext);
   assign last_item = (N_W'(idx_ff) + N_W'(1)) >= n_eff;

   // register writes
   always_comb begin
      mode_in         = mode_ff;
      frame_length_in = frame_length_ff;
      phase_step_in   = phase_step_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WINDOW_MODE: begin
               mode_in = csr_data[MODE_W-1:0];
            end
            CSR_FRAME_LENGTH: begin
               frame_length_in = csr_data[FRAME_LEN_W-1:0];
            end
            CSR_PHASE_STEP: begin
               phase_step_in = csr_data[PHASE_STEP_W-1:0];
            end
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   // state machine
   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.accept = 1'b1;
               state_in    = ST_COEF;
            end
         end
         ST_COEF: begin
            ctrl.coef_en = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            ctrl.mul_en = 1'b1;
            state_in    = ST_SEND;
         end
         ST_SEND: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl.out_load = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // frame position
   always_comb begin
      idx_in   = idx_ff;
      phase_in = phase_ff;
      if (ctrl.accept) begin
         if (last_item) begin
            idx_in   = '0;
            phase_in = '0;
         end else begin
            idx_in   = idx_ff + IDX_W'(1);
            phase_in = phase_ff + phase_step_ff[PHASE_W-1:0];
         end
      end
   end

   always_comb begin
      if (ctrl.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         mode_ff         <= MODE_PASS;
         frame_length_ff <= FRAME_LEN_RESET;
         phase_step_ff   <= PHASE_STEP_RESET;
         idx_ff          <= '0;
         phase_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         mode_ff         <= mode_in;
         frame_length_ff <= frame_length_in;
         phase_step_ff   <= phase_step_in;
         idx_ff          <= idx_in;
         phase_ff        <= phase_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign phase     = phase_ff;
   assign mode      = mode_ff;
   assign last_out  = last_item;

`ifndef ASSERT_OFF
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (ctrl.accept && last_item) |=> (idx_ff == '0) && (phase_ff == '0))
      else $error("frame did not restart after its last beat");

   a_single_phase: assert property (@(posedge clock) disable iff (reset)
      (ctrl.accept && (frame_length_ff <= FRAME_LEN_W'(1))) |=> (phase_ff == '0))
      else $error("phase moved in a single-sample frame");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (N_W'(idx_ff) < MAX_N))
      else $error("sample index beyond the largest frame");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      ctrl.out_load |=> rsp_valid_ff)
      else $error("loaded result not offered");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !ctrl.out_load)
      else $error("result overwritten before it was taken");
`endif

endmodule
`default_nettype wire

// ===== rtl/hann_hamming_window_apply.sv =====
// An accepted sample beat goes through the cosine ROM read, coefficient register,
//   product register and output register before its result beat on rsp_chan; the
//   sequencer runs these steps in turn for one sample at a time.
// A finished result waits in the output register while the next sample is taken.
// Reset (synchronous, active high) clears index, phase and handshake state and
//   restores mode pass, frame length 1024, phase step 64; the cosine ROM is constant.
`default_nettype none
module hann_hamming_window_apply
   import hhw_pkg::*;
#(
   parameter int unsigned MAX_FRAME       = 4096,
   parameter int unsigned COS_TABLE_DEPTH = 1024,
   parameter int unsigned SAMPLE_WIDTH    = 24
) (
   input wire logic  clock,
   input wire logic  reset,
   hhw_req_if.sink   req_chan,
   hhw_rsp_if.source rsp_chan,
   hhw_csr_if.sink   csr_chan
);

   dp_ctrl_type        ctrl;
   logic [PHASE_W-1:0] phase;
   logic [MODE_W-1:0]  mode;
   logic               last_item;

   hhw_seq #(
      .MAX_FRAME (MAX_FRAME)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .csr_valid (csr_chan.valid),
      .csr_ready (csr_chan.ready),
      .csr_index (csr_chan.index),
      .csr_data  (csr_chan.data),
      .ctrl      (ctrl),
      .phase     (phase),
      .mode      (mode),
      .last_out  (last_item)
   );

   hhw_wdp #(
      .SAMPLE_WIDTH    (SAMPLE_WIDTH),
      .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
   ) u_wdp (
      .clock           (clock),
      .ctrl            (ctrl),
      .sample_in       (req_chan.sample_in),
      .phase           (phase),
      .mode            (mode),
      .last_in         (last_item),
      .windowed_sample (rsp_chan.windowed_sample),
      .last_of_frame   (rsp_chan.last_of_frame)
   );

endmodule
`default_nettype wire
